FILE: hw/rtl/assert_macros.svh
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// property must hold at every clock edge outside reset
`define MDMVA_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// expression must never be true outside reset
`define MDMVA_ASSERT_NEVER(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("forbidden condition seen");

`else

`define MDMVA_ASSERT(label, clk, rst_n, prop)
`define MDMVA_ASSERT_NEVER(label, clk, rst_n, expr)

`endif

`endif

FILE: hw/rtl/mdmva_pkg.sv
// types and constants of the masked matrix-vector accumulator
`timescale 1ns / 1ps

package mdmva_pkg;

  localparam int unsigned VAL_W  = 32;
  localparam int unsigned ACC_W  = 48;
  localparam int unsigned PROD_W = 64;
  localparam int unsigned FRAC_W = 24;
  localparam int unsigned IDX_W  = 6;
  localparam int unsigned APB_AW = 3;
  localparam int unsigned APB_DW = 32;

  // register map, word index taken from paddr bit 2
  localparam logic REG_DUAL_POINT = 1'b0;

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  typedef enum logic [1:0] {
    REQ_LOAD_SRC = 2'd0,
    REQ_SET_DIEL = 2'd1,
    REQ_MAC      = 2'd2,
    REQ_READ     = 2'd3
  } req_type_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MUL,
    ST_WB
  } state_e;

  typedef struct packed {
    req_type_e               req_type;
    logic [IDX_W-1:0]        row_index;
    logic [IDX_W-1:0]        col_index;
    logic signed [VAL_W-1:0] value;
    logic                    flag;
  } in_item_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] potential;
    logic                    read_valid;
    logic                    saturated;
  } out_item_t;

  typedef struct packed {
    logic                    dummy;
    logic signed [VAL_W-1:0] value;
  } src_entry_t;

  typedef struct packed {
    logic                    dielectric;
    logic signed [ACC_W-1:0] potential;
  } row_entry_t;

endpackage

FILE: hw/rtl/masked_direct_matvec_accumulate.sv
// top level: request sequencing, state memories and configuration port
//
// Usage
//   Input channel in_valid_i / in_stall_o carries one request (in_req_i):
//   load source charge, set row dielectric flag, coefficient multiply-add,
//   or read-and-clear of a row potential. Every request gives exactly one
//   result on out_valid_o / out_stall_i (out_item_o), in request order.
//   Each request is accepted with a memory read, multiplied into the
//   product register, then accumulated and written back into the row
//   memory while the result is loaded into the output register. One request
//   is in flight at a time, so a new request is taken only after the last
//   is written back; the next request is accepted while a result still waits.
//   After reset the row memory (potentials and dielectric flags) is swept
//   to zero, one row at a time, and in_stall_o stays high meanwhile;
//   source charges are not cleared and must be loaded before use.
//   When the receiver stalls, the result holds in the output register and
//   the pending write-back waits, so no request is lost.
//   dual_point_mode is written through the APB port at address 0; the user
//   must write it only while the block is idle; the block does not enforce it.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module masked_direct_matvec_accumulate
  import mdmva_pkg::*;
#(
  parameter int unsigned MAX_ELEMS = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // request channel
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  in_item_t          in_req_i,
  // result channel
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output out_item_t         out_item_o,
  // configuration port
  input  logic              psel_i,
  input  logic              penable_i,
  input  logic              pwrite_i,
  input  logic [APB_AW-1:0] paddr_i,
  input  logic [APB_DW-1:0] pwdata_i,
  output logic [APB_DW-1:0] prdata_o,
  output logic              pready_o
);

  localparam int unsigned AW = $clog2(MAX_ELEMS);
  localparam logic [AW-1:0] LAST_ROW = AW'(MAX_ELEMS - 1);

  state_e     state_q, state_d;
  in_item_t   req_q;
  logic       row_ok_q, col_ok_q;
  logic       mode_q;
  logic [AW-1:0] clr_q, clr_d;
  logic       out_valid_q, out_valid_d;
  out_item_t  out_item_q, out_item_d;

  logic       accept;
  logic       in_row_ok, in_col_ok;
  logic       out_free;
  logic       wb_go;
  logic       mul_en;
  logic       cfg_wr;

  src_entry_t src_rd, src_wdata;
  row_entry_t row_rd, row_upd, row_wdata;
  logic       row_upd_we;
  logic       row_we;
  logic [AW-1:0] row_waddr;
  out_item_t  result;

  logic signed [ACC_W-1:0] mac_sum;
  logic                    mac_sat;

  // handshake
  assign accept    = in_valid_i && !in_stall_o;
  assign in_stall_o = state_q != ST_IDLE;
  assign out_free  = !out_valid_q || !out_stall_i;
  assign wb_go     = (state_q == ST_WB) && out_free;
  assign mul_en    = state_q == ST_MUL;

  // range checks on the request indexes
  assign in_row_ok = {26'd0, in_req_i.row_index} < 32'(MAX_ELEMS);
  assign in_col_ok = {26'd0, in_req_i.col_index} < 32'(MAX_ELEMS);

  // source charges and dummy marks
  assign src_wdata = '{dummy: in_req_i.flag, value: in_req_i.value};

  mdmva_ram #(
    .WIDTH ($bits(src_entry_t)),
    .DEPTH (MAX_ELEMS),
    .AW    (AW)
  ) u_src_ram (
    .clk_i   (clk_i),
    .we_i    (accept && in_req_i.req_type == REQ_LOAD_SRC && in_col_ok),
    .waddr_i (AW'(in_req_i.col_index)),
    .wdata_i (src_wdata),
    .re_i    (accept),
    .raddr_i (AW'(in_req_i.col_index)),
    .rdata_o (src_rd)
  );

  // row potentials and dielectric flags
  mdmva_ram #(
    .WIDTH ($bits(row_entry_t)),
    .DEPTH (MAX_ELEMS),
    .AW    (AW)
  ) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (row_we),
    .waddr_i (row_waddr),
    .wdata_i (row_wdata),
    .re_i    (accept),
    .raddr_i (AW'(in_req_i.row_index)),
    .rdata_o (row_rd)
  );

  // multiply and saturating add
  mdmva_mac u_mac (
    .clk_i    (clk_i),
    .mul_en_i (mul_en),
    .coef_i   (req_q.value),
    .charge_i (src_rd.value),
    .acc_i    (row_rd.potential),
    .sum_o    (mac_sum),
    .sat_o    (mac_sat)
  );

  // write-back value and result per request type
  always_comb begin
    row_upd    = row_rd;
    row_upd_we = 1'b0;
    result     = '0;
    case (req_q.req_type)
      REQ_LOAD_SRC: begin
        row_upd_we = 1'b0;
      end
      REQ_SET_DIEL: begin
        if (row_ok_q) begin
          row_upd_we         = 1'b1;
          row_upd.dielectric = req_q.flag;
        end
      end
      REQ_MAC: begin
        if (row_ok_q && col_ok_q && !src_rd.dummy && !(mode_q && row_rd.dielectric)) begin
          row_upd_we        = 1'b1;
          row_upd.potential = mac_sum;
          result.saturated  = mac_sat;
        end
      end
      REQ_READ: begin
        result.read_valid = 1'b1;
        if (row_ok_q) begin
          result.potential  = row_rd.potential;
          row_upd_we        = 1'b1;
          row_upd.potential = '0;
        end
      end
      default: begin
        row_upd_we = 1'b0;
      end
    endcase
  end

  // row memory write port: clearing sweep or write-back
  always_comb begin
    if (state_q == ST_CLEAR) begin
      row_we    = 1'b1;
      row_waddr = clr_q;
      row_wdata = '0;
    end else begin
      row_we    = wb_go && row_upd_we;
      row_waddr = AW'(req_q.row_index);
      row_wdata = row_upd;
    end
  end

  // sequencer next state
  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    case (state_q)
      ST_CLEAR: begin
        clr_d = clr_q + 1'b1;
        if (clr_q == LAST_ROW) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        state_d = ST_WB;
      end
      ST_WB: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    out_item_d  = out_item_q;
    if (wb_go) begin
      out_valid_d = 1'b1;
      out_item_d  = result;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      mode_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
      if (cfg_wr && paddr_i[2] == REG_DUAL_POINT) begin
        mode_q <= pwdata_i[0];
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q    <= in_req_i;
      row_ok_q <= in_row_ok;
      col_ok_q <= in_col_ok;
    end
    out_item_q <= out_item_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // configuration port
  assign pready_o = 1'b1;
  assign cfg_wr   = psel_i && penable_i && pwrite_i;

  always_comb begin
    prdata_o = '0;
    if (paddr_i[2] == REG_DUAL_POINT) begin
      prdata_o[0] = mode_q;
    end
  end

  // one request in flight: an accepted request blocks the next cycle
  `MDMVA_ASSERT(a_one_in_flight, clk_i, rst_ni, accept |=> in_stall_o)
  // a finished write-back always shows a result next cycle
  `MDMVA_ASSERT(a_wb_gives_result, clk_i, rst_ni, wb_go |=> out_valid_o)
  // read results never report saturation
  `MDMVA_ASSERT_NEVER(a_read_not_sat, clk_i, rst_ni,
    out_valid_o && out_item_o.read_valid && out_item_o.saturated)
  // non-read results carry zero potential
  `MDMVA_ASSERT_NEVER(a_nonread_zero, clk_i, rst_ni,
    out_valid_o && !out_item_o.read_valid && out_item_o.potential != '0)

endmodule

FILE: hw/rtl/mdmva_ram.sv
// single-port-write, registered-read memory
`timescale 1ns / 1ps

module mdmva_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read port, registered
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/mdmva_mac.sv
// registered multiply and saturating accumulate
`timescale 1ns / 1ps

module mdmva_mac
  import mdmva_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    mul_en_i,
  input  logic signed [VAL_W-1:0] coef_i,
  input  logic signed [VAL_W-1:0] charge_i,
  input  logic signed [ACC_W-1:0] acc_i,
  output logic signed [ACC_W-1:0] sum_o,
  output logic                    sat_o
);

  localparam int unsigned SH_W = PROD_W - FRAC_W;

  logic signed [PROD_W-1:0] prod_q;
  logic signed [PROD_W-1:0] prod_d;
  logic signed [SH_W-1:0]   shifted;
  logic signed [ACC_W:0]    sum_wide;

  // full product, registered before the add
  assign prod_d = coef_i * charge_i;

  always_ff @(posedge clk_i) begin
    if (mul_en_i) begin
      prod_q <= prod_d;
    end
  end

  // drop fraction bits, floor rounding
  assign shifted = prod_q[PROD_W-1:FRAC_W];

  // one guard bit catches overflow of the 48-bit sum
  assign sum_wide = {acc_i[ACC_W-1], acc_i}
                  + {{(ACC_W+1-SH_W){shifted[SH_W-1]}}, shifted};

  always_comb begin
    sat_o = sum_wide[ACC_W] != sum_wide[ACC_W-1];
    if (!sat_o) begin
      sum_o = sum_wide[ACC_W-1:0];
    end else if (sum_wide[ACC_W]) begin
      sum_o = ACC_MIN;
    end else begin
      sum_o = ACC_MAX;
    end
  end

endmodule

FILE: tb/sv/masked_direct_matvec_accumulate_test.sv
// self-checking testbench for the masked matrix-vector accumulator
`timescale 1ns / 1ps

module masked_direct_matvec_accumulate_test;
  import mdmva_pkg::*;

  localparam int MAX_ELEMS     = 64;
  localparam int HOLD_CYCLES   = 160;
  localparam int DRAIN_PAUSE   = 8;
  localparam int PHASE_ITEMS   = 180;
  localparam int BURST_LEN     = 520;
  localparam int CYCLE_LIMIT   = 400000;
  localparam logic [APB_AW-1:0] DUAL_ADDR = {REG_DUAL_POINT, 2'b00};

  // predicts row potentials and checks results in request order
  class potential_checker;
    bit                      dual_mode;
    logic signed [VAL_W-1:0] charge [MAX_ELEMS];
    bit                      dummy [MAX_ELEMS];
    bit                      dielectric [MAX_ELEMS];
    longint                  row_pot [MAX_ELEMS];
    out_item_t               expected_results [$];
    int                      mismatches;

    function new();
      dual_mode  = 1'b0;
      mismatches = 0;
      for (int i = 0; i < MAX_ELEMS; i++) begin
        charge[i]     = '0;
        dummy[i]      = 1'b0;
        dielectric[i] = 1'b0;
        row_pot[i]    = 0;
      end
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    function void report(string what, longint want, longint got);
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch %s: expected %0d, got %0d", what, want, got);
    endfunction

    // work out the result of one accepted request
    function void note_request(in_item_t req);
      out_item_t want;
      int        r;
      int        c;
      longint    prod;
      longint    sum;
      want = '0;
      r = int'(req.row_index);
      c = int'(req.col_index);
      case (req.req_type)
        REQ_LOAD_SRC: begin
          if (c < MAX_ELEMS) begin
            charge[c] = req.value;
            dummy[c]  = req.flag;
          end
        end
        REQ_SET_DIEL: begin
          if (r < MAX_ELEMS) dielectric[r] = req.flag;
        end
        REQ_MAC: begin
          if (r < MAX_ELEMS && c < MAX_ELEMS && !dummy[c] &&
              !(dual_mode && dielectric[r])) begin
            prod = longint'($signed(req.value)) * longint'($signed(charge[c]));
            // q16.48 to q24.24, floor
            sum = row_pot[r] + (prod >>> FRAC_W);
            if (sum > longint'(ACC_MAX)) begin
              sum = longint'(ACC_MAX);
              want.saturated = 1'b1;
            end else if (sum < longint'(ACC_MIN)) begin
              sum = longint'(ACC_MIN);
              want.saturated = 1'b1;
            end
            row_pot[r] = sum;
          end
        end
        REQ_READ: begin
          want.read_valid = 1'b1;
          if (r < MAX_ELEMS) begin
            want.potential = row_pot[r][ACC_W-1:0];
            row_pot[r]     = 0;
          end
        end
        default: begin
          want = '0;
        end
      endcase
      expected_results.push_back(want);
    endfunction

    // compare one accepted result with the oldest expectation
    function void check_result(out_item_t got);
      out_item_t want;
      if (expected_results.size() == 0) begin
        report("result with no request pending, potential", 0, got.potential);
        return;
      end
      want = expected_results.pop_front();
      if (got.potential !== want.potential)
        report("potential", want.potential, got.potential);
      if (got.read_valid !== want.read_valid)
        report("read_valid", want.read_valid, got.read_valid);
      if (got.saturated !== want.saturated)
        report("saturated", want.saturated, got.saturated);
    endfunction

    function void final_check();
      if (expected_results.size() != 0)
        report("results never delivered", 0, expected_results.size());
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_stall_o;
  in_item_t          in_req_i;
  logic              out_valid_o;
  logic              out_stall_i;
  out_item_t         out_item_o;
  logic              psel_i;
  logic              penable_i;
  logic              pwrite_i;
  logic [APB_AW-1:0] paddr_i;
  logic [APB_DW-1:0] pwdata_i;
  logic [APB_DW-1:0] prdata_o;
  logic              pready_o;

  potential_checker  sb;
  int                send_idle_pct;
  int                recv_idle_pct;
  bit                hold_req;
  int unsigned       cycle_count;
  bit                src_loaded [MAX_ELEMS];
  int                loaded_cols [$];

  masked_direct_matvec_accumulate #(
    .MAX_ELEMS(MAX_ELEMS)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o),
    .psel_i     (psel_i),
    .penable_i  (penable_i),
    .pwrite_i   (pwrite_i),
    .paddr_i    (paddr_i),
    .pwdata_i   (pwdata_i),
    .prdata_o   (prdata_o),
    .pready_o   (pready_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // cycle counter and timeout
  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Regression FAIL");
    $finish;
  end

  // result receiver: random stalls plus one long hold-off on request
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req    <= 1'b0;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0)
      sb.check_result(out_item_o);
  end

  function automatic in_item_t make_req(req_type_e t, int row, int col,
                                        logic [VAL_W-1:0] v, bit f);
    in_item_t req;
    req.req_type  = t;
    req.row_index = IDX_W'(row);
    req.col_index = IDX_W'(col);
    req.value     = v;
    req.flag      = f;
    return req;
  endfunction

  function automatic logic [IDX_W-1:0] pick_index();
    if ($urandom_range(3) != 0) return IDX_W'($urandom_range(7));
    return IDX_W'($urandom_range(MAX_ELEMS - 1));
  endfunction

  // charges and coefficients, extremes weighted in
  function automatic logic [VAL_W-1:0] rand_value();
    logic [VAL_W-1:0] v;
    case ($urandom_range(9))
      0:       v = 32'h8000_0000;
      1:       v = 32'h7fff_ffff;
      2:       v = '0;
      3:       v = '1;
      4, 5:    v = $urandom_range(32'h01ff_ffff) - 32'h0100_0000;
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // well-formed random request; multiply-adds only use loaded sources
  function automatic in_item_t random_request();
    in_item_t req;
    int       pick;
    req.row_index = IDX_W'($urandom);
    req.col_index = IDX_W'($urandom);
    req.value     = $urandom;
    req.flag      = 1'($urandom);
    pick = $urandom_range(99);
    if (pick < 14 || loaded_cols.size() == 0) begin
      req.req_type  = REQ_LOAD_SRC;
      req.col_index = pick_index();
      req.value     = rand_value();
      req.flag      = ($urandom_range(4) == 0);
    end else if (pick < 24) begin
      req.req_type  = REQ_SET_DIEL;
      req.row_index = pick_index();
    end else if (pick < 80) begin
      req.req_type  = REQ_MAC;
      req.row_index = pick_index();
      req.col_index = IDX_W'(loaded_cols[$urandom_range(loaded_cols.size() - 1)]);
      req.value     = rand_value();
    end else begin
      req.req_type  = REQ_READ;
      req.row_index = pick_index();
    end
    return req;
  endfunction

  // offer one request from a falling edge, return at the falling edge after it
  task automatic send_request(input in_item_t req);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= req;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    sb.note_request(req);
    if (req.req_type == REQ_LOAD_SRC && !src_loaded[req.col_index]) begin
      src_loaded[req.col_index] = 1'b1;
      loaded_cols.push_back(int'(req.col_index));
    end
    @(negedge clk_i);
  endtask

  // stop offering and wait until every result is back
  task automatic wait_drain();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_PAUSE) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic apb_access(input bit wr, input logic [APB_DW-1:0] wdata,
                            output logic [APB_DW-1:0] rdata);
    psel_i    <= 1'b1;
    penable_i <= 1'b0;
    pwrite_i  <= wr;
    paddr_i   <= DUAL_ADDR;
    pwdata_i  <= wdata;
    @(negedge clk_i);
    penable_i <= 1'b1;
    do @(posedge clk_i); while (pready_o !== 1'b1);
    rdata = prdata_o;
    @(negedge clk_i);
    psel_i    <= 1'b0;
    penable_i <= 1'b0;
    pwrite_i  <= 1'b0;
    @(negedge clk_i);
  endtask

  // write the mode register and read it back
  task automatic set_dual_mode(input bit mode);
    logic [APB_DW-1:0] rd;
    apb_access(1'b1, {{(APB_DW-1){1'b0}}, mode}, rd);
    sb.dual_mode = mode;
    apb_access(1'b0, '0, rd);
    if (rd !== {{(APB_DW-1){1'b0}}, mode})
      sb.report("dual_point_mode readback", mode, rd);
  endtask

  // drive one row into saturation with full-scale products, then read it
  task automatic saturation_burst(input int row, input int col,
                                  input logic [VAL_W-1:0] chg,
                                  input logic [VAL_W-1:0] coef);
    send_request(make_req(REQ_SET_DIEL, row, $urandom, $urandom, 1'b0));
    send_request(make_req(REQ_LOAD_SRC, $urandom, col, chg, 1'b0));
    repeat (BURST_LEN) send_request(make_req(REQ_MAC, row, col, coef, 1'($urandom)));
    send_request(make_req(REQ_READ, row, $urandom, $urandom, 1'($urandom)));
  endtask

  task automatic run_phase(input int items, input bit hold_mid, input bit pause_mid);
    for (int i = 0; i < items; i++) begin
      if (hold_mid && i == items / 3) hold_req <= 1'b1;
      if (pause_mid && i == items / 2) wait_drain();
      send_request(random_request());
    end
  endtask

  // main sequence
  initial begin
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    in_req_i      = '0;
    psel_i        = 1'b0;
    penable_i     = 1'b0;
    pwrite_i      = 1'b0;
    paddr_i       = '0;
    pwdata_i      = '0;
    hold_req      = 1'b0;
    cycle_count   = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int i = 0; i < MAX_ELEMS; i++) src_loaded[i] = 1'b0;
    sb = new();

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // row memory clear sweep after reset
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    @(negedge clk_i);
    set_dual_mode(1'b1);

    // directed: extremes, dummy source, dielectric skip, read clears
    send_request(make_req(REQ_LOAD_SRC, 7, 0, 32'h7fff_ffff, 1'b0));
    send_request(make_req(REQ_LOAD_SRC, 9, 1, 32'h8000_0000, 1'b0));
    send_request(make_req(REQ_LOAD_SRC, 0, 2, 32'h0100_0000, 1'b0));
    send_request(make_req(REQ_LOAD_SRC, 63, 3, 32'h1234_5678, 1'b1));
    send_request(make_req(REQ_LOAD_SRC, 21, 63, 32'hffff_ffff, 1'b0));
    send_request(make_req(REQ_SET_DIEL, 5, 44, 32'hdead_beef, 1'b1));
    send_request(make_req(REQ_SET_DIEL, 63, 0, 32'h0, 1'b0));
    send_request(make_req(REQ_MAC, 0, 1, 32'h8000_0000, 1'b1));
    send_request(make_req(REQ_MAC, 0, 0, 32'h8000_0000, 1'b0));
    send_request(make_req(REQ_MAC, 1, 2, 32'hffff_ffff, 1'b0));
    send_request(make_req(REQ_MAC, 1, 63, 32'h0000_0001, 1'b1));
    send_request(make_req(REQ_MAC, 0, 3, 32'h7fff_ffff, 1'b0));
    send_request(make_req(REQ_MAC, 5, 2, 32'h7fff_ffff, 1'b0));
    send_request(make_req(REQ_MAC, 63, 0, 32'h7fff_ffff, 1'b0));
    send_request(make_req(REQ_READ, 0, 63, 32'hffff_ffff, 1'b1));
    send_request(make_req(REQ_READ, 1, 0, 32'h0, 1'b0));
    send_request(make_req(REQ_READ, 5, 17, 32'h5555_aaaa, 1'b1));
    send_request(make_req(REQ_READ, 63, 2, 32'h0, 1'b0));
    send_request(make_req(REQ_READ, 0, 0, 32'h0, 1'b0));
    send_request(make_req(REQ_SET_DIEL, 5, 0, 32'h0, 1'b0));
    send_request(make_req(REQ_MAC, 5, 2, 32'h0100_0000, 1'b0));
    send_request(make_req(REQ_READ, 5, 0, 32'h0, 1'b0));
    send_request(make_req(REQ_READ, 42, 51, 32'haaaa_5555, 1'b1));

    // sender idles lightly, receiver heavily; long receiver hold-off
    wait_drain();
    set_dual_mode(1'b0);
    send_idle_pct = 13;
    recv_idle_pct = 51;
    saturation_burst(9, 10, 32'h8000_0000, 32'h8000_0000);
    run_phase(PHASE_ITEMS, 1'b1, 1'b0);

    // sender idles heavily, receiver lightly; sender pauses until drained
    wait_drain();
    set_dual_mode(1'b1);
    send_idle_pct = 51;
    recv_idle_pct = 13;
    saturation_burst(11, 12, 32'h7fff_ffff, 32'h8000_0000);
    run_phase(PHASE_ITEMS, 1'b0, 1'b1);

    // back to back on both sides
    wait_drain();
    set_dual_mode(1'b0);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_phase(PHASE_ITEMS, 1'b0, 1'b0);

    wait_drain();
    sb.final_check();
    if (sb.mismatches == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

FILE: masked_direct_matvec_accumulate.f
+incdir+hw/rtl
hw/rtl/mdmva_pkg.sv
hw/rtl/mdmva_ram.sv
hw/rtl/mdmva_mac.sv
hw/rtl/masked_direct_matvec_accumulate.sv
tb/sv/masked_direct_matvec_accumulate_test.sv
